// File: src/volos_pkg.sv
package volos_pkg;

    localparam int MAX_DIM    = 64;
    localparam int BRICK_EDGE = 4;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 6;
    localparam int RES_W      = 7;
    localparam int RES_MIN    = BRICK_EDGE;
    localparam int RES_RESET  = 64;
    localparam int NB         = (MAX_DIM + BRICK_EDGE - 1) / BRICK_EDGE;
    localparam int DEPTH      = NB * NB * NB;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int AW1        = ADDR_W + 1;
    localparam int NB_W       = $clog2(NB + 1);
    localparam int NBXY_W     = $clog2(NB * NB + 1);
    localparam int WORD_W     = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_W      = COORD_W + FRAC_BITS;
    localparam int INC_W      = FRAC_BITS + 1;
    localparam int SINC_W     = INC_W + 1;
    localparam int CPOS_W     = COORD_W + 2;
    localparam int POS_W      = CPOS_W + FRAC_BITS + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Z = 2'd2;

    typedef enum logic [1:0] {
        MODE_CHECK,
        MODE_SET,
        MODE_CLEAR,
        MODE_LOS
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_DIVGO,
        S_DIVWAIT,
        S_WALK,
        S_WTEST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [RES_W-1:0]  res_x;
        logic [RES_W-1:0]  res_y;
        logic [RES_W-1:0]  res_z;
        logic [NB_W-1:0]   nbx;
        logic [NBXY_W-1:0] nbxy;
        logic              clearing;
    } t_geom;

    typedef struct packed {
        t_mode               mode;
        logic                in_range;
        logic [ADDR_W-1:0]   addr;
        logic [BIT_W-1:0]    bitsel;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  sz;
        logic [COORD_W-1:0]  gx;
        logic [COORD_W-1:0]  gy;
        logic [COORD_W-1:0]  gz;
        logic [COORD_W-1:0]  mx;
        logic [COORD_W-1:0]  my;
        logic [COORD_W-1:0]  mz;
        logic                nx;
        logic                ny;
        logic                nz;
        logic [COORD_W-1:0]  steps;
    } t_req;

    function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] v);
        logic [RES_W-1:0] r;
        r = v;
        if (r < RES_W'(RES_MIN)) begin
            r = RES_W'(RES_MIN);
        end
        if (r > RES_W'(MAX_DIM)) begin
            r = RES_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic coord_inside(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] z,
                                          input t_geom g);
        return (RES_W'(x) < g.res_x) && (RES_W'(y) < g.res_y) && (RES_W'(z) < g.res_z);
    endfunction

    function automatic logic [ADDR_W-1:0] brick_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [COORD_W-1:0] z,
                                                     input t_geom g);
        logic [AW1-1:0] acc;
        acc = AW1'(z[COORD_W-1:2]) * AW1'(g.nbxy)
            + AW1'(y[COORD_W-1:2]) * AW1'(g.nbx)
            + AW1'(x[COORD_W-1:2]);
        return acc[ADDR_W-1:0];
    endfunction

    function automatic logic [BIT_W-1:0] voxel_bit(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
        return {z[1:0], y[1:0], x[1:0]};
    endfunction

endpackage

// File: src/volos_ram.sv
module volos_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/volos_div.sv
module volos_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [volos_pkg::NUM_W-1:0]    i_num,
    input  logic [volos_pkg::COORD_W-1:0]  i_den,
    output logic                           o_done,
    output logic [volos_pkg::INC_W-1:0]    o_quot
);
    import volos_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_W-1:0]     r_q;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_den;
    logic [COORD_W:0]     trial;
    logic                 ge;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? COORD_W'(trial - {1'b0, r_den}) : trial[COORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[INC_W-1:0];

endmodule

// File: src/volos_front.sv
module volos_front (
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [volos_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [1:0]                  i_s_tuser,
    input  volos_pkg::t_geom            i_geom,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output volos_pkg::t_req             o_q_data
);
    import volos_pkg::*;

    logic [COORD_W-1:0] sx, sy, sz, gx, gy, gz;
    logic [COORD_W-1:0] mx, my, mz, mxy;
    t_req               req;

    assign sx = i_s_tdata[0*COORD_W +: COORD_W];
    assign sy = i_s_tdata[1*COORD_W +: COORD_W];
    assign sz = i_s_tdata[2*COORD_W +: COORD_W];
    assign gx = i_s_tdata[3*COORD_W +: COORD_W];
    assign gy = i_s_tdata[4*COORD_W +: COORD_W];
    assign gz = i_s_tdata[5*COORD_W +: COORD_W];

    assign mx  = (gx >= sx) ? gx - sx : sx - gx;
    assign my  = (gy >= sy) ? gy - sy : sy - gy;
    assign mz  = (gz >= sz) ? gz - sz : sz - gz;
    assign mxy = (mx > my) ? mx : my;

    always_comb begin
        req          = '0;
        req.mode     = t_mode'(i_s_tuser);
        req.in_range = coord_inside(sx, sy, sz, i_geom);
        req.addr     = brick_addr(sx, sy, sz, i_geom);
        req.bitsel   = voxel_bit(sx, sy, sz);
        req.sx       = sx;
        req.sy       = sy;
        req.sz       = sz;
        req.gx       = gx;
        req.gy       = gy;
        req.gz       = gz;
        req.mx       = mx;
        req.my       = my;
        req.mz       = mz;
        req.nx       = gx < sx;
        req.ny       = gy < sy;
        req.nz       = gz < sz;
        req.steps    = (mxy > mz) ? mxy : mz;
    end

    // hold off requests while the store is being wiped or the queue is full
    assign o_s_tready = !i_geom.clearing && !i_q_full;
    assign o_q_push   = i_s_tvalid && o_s_tready;
    assign o_q_data   = req;

endmodule

// File: src/volos_fifo.sv
module volos_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  volos_pkg::t_req  i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output volos_pkg::t_req  o_data
);
    import volos_pkg::*;

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= QPTR_W'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= QPTR_W'(r_rptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_data  = r_mem[r_rptr];

endmodule

// File: src/volos_back.sv
module volos_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [volos_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [volos_pkg::RES_W-1:0]        i_cfg_data,
    input  logic                               i_q_valid,
    input  volos_pkg::t_req                    i_q_data,
    output logic                               o_q_pop,
    output volos_pkg::t_geom                   o_geom,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [volos_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import volos_pkg::*;

    t_state             r_state, n_state;
    t_req               r_cur, n_cur;
    logic [1:0]         r_axis, n_axis;
    logic [SINC_W-1:0]  r_inc [3];
    logic [SINC_W-1:0]  n_inc [3];
    logic [POS_W-1:0]   r_pos [3];
    logic [POS_W-1:0]   n_pos [3];
    logic [COORD_W-1:0] r_cnt, n_cnt;
    logic [BIT_W-1:0]   r_cbit, n_cbit;
    logic               r_ans, n_ans;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [RES_W-1:0]   r_res_x, r_res_y, r_res_z;
    logic               r_out_valid, n_out_valid;
    logic               r_out_ans, n_out_ans;
    logic               r_out_inr, n_out_inr;

    t_geom              geom;
    logic [NB_W-1:0]    nby;
    logic               cfg_hit;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [COORD_W-1:0] div_mag;
    logic               div_neg;
    logic               div_done;
    logic [INC_W-1:0]   div_quot;

    logic [POS_W-1:0]   rnd [3];
    logic [CPOS_W-1:0]  cc [3];
    logic               cneg [3];
    logic               goal_hit;
    logic               cin;
    logic               last_step;

    // brick counts follow the resolution
    always_comb begin
        geom          = '0;
        geom.res_x    = r_res_x;
        geom.res_y    = r_res_y;
        geom.res_z    = r_res_z;
        geom.nbx      = NB_W'((r_res_x + RES_W'(BRICK_EDGE - 1)) >> 2);
        nby           = NB_W'((r_res_y + RES_W'(BRICK_EDGE - 1)) >> 2);
        geom.nbxy     = NBXY_W'(NBXY_W'(geom.nbx) * NBXY_W'(nby));
        geom.clearing = r_state == S_CLEAR;
    end

    assign o_geom  = geom;
    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_RES_X || i_cfg_index == CFG_RES_Y
                                  || i_cfg_index == CFG_RES_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_x <= RES_W'(RES_RESET);
            r_res_y <= RES_W'(RES_RESET);
            r_res_z <= RES_W'(RES_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RES_X: r_res_x <= clamp_res(i_cfg_data);
                CFG_RES_Y: r_res_y <= clamp_res(i_cfg_data);
                CFG_RES_Z: r_res_z <= clamp_res(i_cfg_data);
                default: ;
            endcase
        end
    end

    volos_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // divider operands for the current axis
    always_comb begin
        unique case (r_axis)
            2'd0:    begin div_mag = r_cur.mx; div_neg = r_cur.nx; end
            2'd1:    begin div_mag = r_cur.my; div_neg = r_cur.ny; end
            default: begin div_mag = r_cur.mz; div_neg = r_cur.nz; end
        endcase
        div_num = NUM_W'({div_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(r_cur.steps >> 1);
    end

    volos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_cur.steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // round the walk position to the nearest voxel; test it against the goal and the grid and flag the last step
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k]  = r_pos[k] + POS_W'(1 << (FRAC_BITS - 1));
            cc[k]   = rnd[k][FRAC_BITS +: CPOS_W];
            cneg[k] = r_pos[k][POS_W-1];
        end
        goal_hit = !cneg[0] && !cneg[1] && !cneg[2]
                   && cc[0] == CPOS_W'(r_cur.gx) && cc[1] == CPOS_W'(r_cur.gy)
                   && cc[2] == CPOS_W'(r_cur.gz);
        cin = !cneg[0] && !cneg[1] && !cneg[2]
              && cc[0] < CPOS_W'(r_res_x) && cc[1] < CPOS_W'(r_res_y)
              && cc[2] < CPOS_W'(r_res_z);
        last_step = COORD_W'(r_cnt + 1'b1) == r_cur.steps;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_axis      = r_axis;
        n_inc       = r_inc;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_cbit      = r_cbit;
        n_ans       = r_ans;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ans   = r_out_ans;
        n_out_inr   = r_out_inr;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cur.addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = i_q_data.addr;
        div_start   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_data;
                    if (i_q_data.mode == MODE_LOS) begin
                        if (i_q_data.steps == '0) begin
                            n_ans   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_axis  = 2'd0;
                            n_state = S_DIVGO;
                        end
                    end else if (!i_q_data.in_range) begin
                        n_ans   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                ram_wdata[r_cur.bitsel] = r_cur.mode == MODE_SET;
                ram_we  = r_cur.mode == MODE_SET || r_cur.mode == MODE_CLEAR;
                n_ans   = (r_cur.mode == MODE_CHECK) && ram_rdata[r_cur.bitsel];
                n_state = S_DONE;
            end
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (div_done) begin
                    n_inc[r_axis] = div_neg ? SINC_W'(-SINC_W'(div_quot)) : SINC_W'(div_quot);
                    if (r_axis == 2'd2) begin
                        n_pos[0] = POS_W'({r_cur.sx, {FRAC_BITS{1'b0}}});
                        n_pos[1] = POS_W'({r_cur.sy, {FRAC_BITS{1'b0}}});
                        n_pos[2] = POS_W'({r_cur.sz, {FRAC_BITS{1'b0}}});
                        n_cnt    = '0;
                        n_state  = S_WALK;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_DIVGO;
                    end
                end
            end
            S_WALK: begin
                ram_raddr = brick_addr(cc[0][COORD_W-1:0], cc[1][COORD_W-1:0],
                                       cc[2][COORD_W-1:0], geom);
                n_cbit    = voxel_bit(cc[0][COORD_W-1:0], cc[1][COORD_W-1:0],
                                      cc[2][COORD_W-1:0]);
                if (goal_hit) begin
                    n_ans   = 1'b1;
                    n_state = S_DONE;
                end else if (cin) begin
                    n_state = S_WTEST;
                end else if (last_step) begin
                    n_ans   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        n_pos[k] = r_pos[k] + POS_W'(signed'(r_inc[k]));
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WTEST: begin
                if (ram_rdata[r_cbit]) begin
                    n_ans   = 1'b0;
                    n_state = S_DONE;
                end else if (last_step) begin
                    n_ans   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        n_pos[k] = r_pos[k] + POS_W'(signed'(r_inc[k]));
                    end
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ans   = r_ans;
                    n_out_inr   = r_cur.in_range;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a resolution write starts a fresh grid
        if (cfg_hit) begin
            n_state    = S_CLEAR;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_axis    <= n_axis;
        r_inc     <= n_inc;
        r_pos     <= n_pos;
        r_cnt     <= n_cnt;
        r_cbit    <= n_cbit;
        r_ans     <= n_ans;
        r_out_ans <= n_out_ans;
        r_out_inr <= n_out_inr;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - 2){1'b0}}, r_out_inr, r_out_ans};

endmodule

// File: src/voxel_occupancy_line_of_sight.sv
// Occupancy grid of up to 64x64x64 voxels held as one 64-bit word per 4x4x4 brick in a
// single-port-write, registered-read RAM. Each request checks, sets or clears one voxel,
// or walks a fixed-point line from pos toward goal and reports whether goal is visible;
// every request gives exactly one result unless a resolution write aborts it. A front
// stage classifies requests and queues up to two; the back stage executes them. An
// in-range check, set or clear reads its brick word in S_IDLE, tests or updates it in
// S_ACC and reports from S_DONE; a line of sight request runs three serial divisions, one
// per axis, then walks up to 63 steps, reading the RAM only at steps inside the grid (a
// zero-length walk skips both), bounded by the one-bit-a-cycle divider and the RAM read
// latency. After reset, and after every write to a resolution register, the store is
// wiped one word a cycle, all 4096 words, during which no request is taken.
module voxel_occupancy_line_of_sight (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [volos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [volos_pkg::RES_W-1:0]         i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // pos_x, pos_y, pos_z, goal_x, goal_y, goal_z, 6 bits each, zero padding
    input  logic [volos_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // mode
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // answer, in_range, zero padding
    output logic [volos_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import volos_pkg::*;

    t_geom geom;
    t_req  push_data;
    t_req  head_data;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    logic  q_full;

    volos_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_geom     (geom),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (push_data)
    );

    volos_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (head_data)
    );

    volos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_data    (head_data),
        .o_q_pop     (q_pop),
        .o_geom      (geom),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
